// ===== hdl/txc_pkg.sv =====
// ----------------------------------------------------------------------------
// txc_pkg
// Shared constants, types and the address helper function of the text console engine.
// ----------------------------------------------------------------------------
package txc_pkg;

  localparam int HISTORY_ROWS = 256;
  localparam int SCREEN_COLS  = 80;
  localparam int SCREEN_ROWS  = 25;
  localparam int STORE_CELLS  = HISTORY_ROWS * SCREEN_COLS;

  localparam int ROW_W  = $clog2(HISTORY_ROWS);
  localparam int COL_W  = 7;
  localparam int SROW_W = 5;
  localparam int ADDR_W = $clog2(STORE_CELLS);
  localparam int CELL_W = 16;
  localparam int POS_W  = 11;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;
  localparam int CMD_W  = 3;
  localparam int TAB_STEP = 8;

  localparam logic [CMD_W-1:0] CMD_PUT_CHAR    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SCROLL_UP   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SCROLL_DOWN = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_CURSOR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ_CELL   = 3'd5;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_BLANK,
    S_CLEAR,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] wdata;
  } store_req_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_word;
  } result_t;

  function automatic logic [ADDR_W-1:0] phys_addr(input logic [ROW_W-1:0] ring,
                                                  input logic [ROW_W-1:0] hrow,
                                                  input logic [COL_W-1:0] col);
    logic [ROW_W:0]   sum;
    logic [ROW_W-1:0] prow;
    sum = {1'b0, ring} + {1'b0, hrow};
    if (sum >= (ROW_W+1)'(HISTORY_ROWS)) begin
      sum = sum - (ROW_W+1)'(HISTORY_ROWS);
    end
    prow = sum[ROW_W-1:0];
    return ADDR_W'(prow) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col);
  endfunction

endpackage

// ===== hdl/txc_store.sv =====
// ----------------------------------------------------------------------------
// txc_store
// Scrollback cell memory: one port, write or registered read each cycle.
// ----------------------------------------------------------------------------
module txc_store
  import txc_pkg::*;
(
  input  logic              clk,
  input  store_req_t        req,
  output logic [CELL_W-1:0] rd_data
);

  logic [CELL_W-1:0] mem [STORE_CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

// ===== hdl/txc_oreg.sv =====
// ----------------------------------------------------------------------------
// txc_oreg
// Output holding register that parts the engine from the result stream.
// ----------------------------------------------------------------------------
module txc_oreg
  import txc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     res,
  output logic        free,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata
);

  result_t data;

  assign free = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata = {5'b0, data.cursor_pos, data.cell_word};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

endmodule

// ===== hdl/txc_ctrl.sv =====
// ----------------------------------------------------------------------------
// txc_ctrl
// Command sequencer: cursor, ring base and view state, store access and sweeps.
// ----------------------------------------------------------------------------
module txc_ctrl
  import txc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [CHAR_W-1:0] in_char,
  input  logic [SROW_W-1:0] in_row,
  input  logic [COL_W-1:0]  in_col,
  input  logic              cfg_valid,
  input  logic [ATTR_W-1:0] cfg_data,
  output store_req_t        req,
  input  logic [CELL_W-1:0] rd_data,
  input  logic              out_free,
  output logic              res_load,
  output result_t           res
);

  state_t state, state_next;

  logic [CMD_W-1:0]  cmd_q;
  logic [CHAR_W-1:0] ch_q;
  logic [SROW_W-1:0] row_q;
  logic [COL_W-1:0]  colin_q;
  logic [ROW_W-1:0]  ring;
  logic [ROW_W-1:0]  line;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  view;
  logic [ATTR_W-1:0] attr;
  logic [ATTR_W-1:0] sweep_attr;
  logic [ADDR_W-1:0] cnt;
  logic [CELL_W-1:0] word;

  logic [ROW_W:0]    line_inc;
  logic [ROW_W-1:0]  top;
  logic [ROW_W-1:0]  diff;
  logic [ROW_W:0]    vis;
  logic [POS_W-1:0]  cur_pos;

  logic [ROW_W:0]    pc_line;
  logic [COL_W-1:0]  pc_col;
  logic              pc_we;
  logic [COL_W-1:0]  pc_wcol;
  logic [CHAR_W-1:0] pc_wchar;
  logic              pc_ovf;
  logic [COL_W:0]    col_sum;

  logic [ROW_W-1:0]  start;
  logic [ROW_W:0]    hrow;
  logic              rc_oob;
  logic              rc_hit;
  logic [ROW_W:0]    sc_row;

  logic              sweep_last;
  logic              blank_last;

  assign line_inc = {1'b0, line} + (ROW_W+1)'(1);
  assign top = (line_inc >= (ROW_W+1)'(SCREEN_ROWS)) ?
               ROW_W'(line_inc - (ROW_W+1)'(SCREEN_ROWS)) : '0;
  assign diff = line - top;
  assign vis = {1'b0, diff} + {1'b0, view};
  assign cur_pos = (vis >= (ROW_W+1)'(SCREEN_ROWS)) ? POS_W'(SCREEN_ROWS * SCREEN_COLS) :
                   POS_W'(POS_W'(vis) * POS_W'(SCREEN_COLS) + POS_W'(col));

  assign start = (top > view) ? top - view : '0;
  assign hrow = {1'b0, start} + (ROW_W+1)'(row_q);
  assign rc_oob = (row_q >= SROW_W'(SCREEN_ROWS)) || (colin_q >= COL_W'(SCREEN_COLS));
  assign rc_hit = hrow <= {1'b0, line};
  assign sc_row = {1'b0, top} + (ROW_W+1)'(row_q);

  assign sweep_last = cnt == ADDR_W'(STORE_CELLS - 1);
  assign blank_last = cnt == ADDR_W'(SCREEN_COLS - 1);

  always_comb begin
    pc_line  = {1'b0, line};
    pc_col   = col;
    pc_we    = 1'b0;
    pc_wcol  = col;
    pc_wchar = ch_q;
    col_sum  = '0;
    case (ch_q)
      CH_NL: begin
        pc_col  = '0;
        pc_line = line_inc;
      end
      CH_CR: begin
        pc_col = '0;
      end
      CH_TAB: begin
        col_sum = ({1'b0, col} + (COL_W+1)'(TAB_STEP)) & ~(COL_W+1)'(TAB_STEP - 1);
        if (col_sum >= (COL_W+1)'(SCREEN_COLS)) begin
          pc_col  = '0;
          pc_line = line_inc;
        end else begin
          pc_col = col_sum[COL_W-1:0];
        end
      end
      CH_BS: begin
        if (col != '0) begin
          pc_col   = col - COL_W'(1);
          pc_we    = 1'b1;
          pc_wcol  = col - COL_W'(1);
          pc_wchar = CH_SPACE;
        end
      end
      default: begin
        pc_we   = 1'b1;
        col_sum = {1'b0, col} + (COL_W+1)'(1);
        if (col_sum >= (COL_W+1)'(SCREEN_COLS)) begin
          pc_col  = '0;
          pc_line = line_inc;
        end else begin
          pc_col = col_sum[COL_W-1:0];
        end
      end
    endcase
  end

  assign pc_ovf = pc_line >= (ROW_W+1)'(HISTORY_ROWS);

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (cmd_q)
          CMD_PUT_CHAR:  state_next = pc_ovf ? S_BLANK : S_RESULT;
          CMD_CLEAR:     state_next = S_CLEAR;
          CMD_READ_CELL: state_next = (!rc_oob && rc_hit) ? S_READ : S_RESULT;
          default:       state_next = S_RESULT;
        endcase
      end
      S_READ: state_next = S_RESULT;
      S_BLANK: begin
        if (blank_last) begin
          state_next = S_RESULT;
        end
      end
      S_CLEAR: begin
        if (sweep_last) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req = '0;
    res_load = 1'b0;
    in_ready = 1'b0;
    res.cell_word = word;
    res.cursor_pos = cur_pos;
    unique case (state)
      S_INIT, S_CLEAR: begin
        req.we    = 1'b1;
        req.addr  = cnt;
        req.wdata = {sweep_attr, CH_SPACE};
      end
      S_IDLE: in_ready = 1'b1;
      S_EXEC: begin
        if (cmd_q == CMD_PUT_CHAR && pc_we) begin
          req.we    = 1'b1;
          req.addr  = phys_addr(ring, line, pc_wcol);
          req.wdata = {attr, pc_wchar};
        end else if (cmd_q == CMD_READ_CELL && !rc_oob && rc_hit) begin
          req.re   = 1'b1;
          req.addr = phys_addr(ring, hrow[ROW_W-1:0], colin_q);
        end
      end
      S_BLANK: begin
        req.we    = 1'b1;
        req.addr  = phys_addr(ring, ROW_W'(HISTORY_ROWS - 1), cnt[COL_W-1:0]);
        req.wdata = {attr, CH_SPACE};
      end
      S_RESULT: res_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      ring       <= '0;
      line       <= '0;
      col        <= '0;
      view       <= '0;
      attr       <= ATTR_RESET;
      sweep_attr <= ATTR_RESET;
      cnt        <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        attr <= cfg_data;
      end
      case (state)
        S_INIT, S_CLEAR, S_BLANK: cnt <= cnt + ADDR_W'(1);
        S_EXEC: begin
          cnt <= '0;
          unique case (cmd_q)
            CMD_PUT_CHAR: begin
              view <= '0;
              col  <= pc_col;
              if (pc_ovf) begin
                ring <= (ring == ROW_W'(HISTORY_ROWS - 1)) ? '0 : ring + ROW_W'(1);
                line <= ROW_W'(HISTORY_ROWS - 1);
              end else begin
                line <= pc_line[ROW_W-1:0];
              end
            end
            CMD_SCROLL_UP: begin
              if (view < top) begin
                view <= view + ROW_W'(1);
              end
            end
            CMD_SCROLL_DOWN: begin
              if (view != '0) begin
                view <= view - ROW_W'(1);
              end
            end
            CMD_SET_CURSOR: begin
              line <= (sc_row >= (ROW_W+1)'(HISTORY_ROWS)) ? ROW_W'(HISTORY_ROWS - 1) :
                      sc_row[ROW_W-1:0];
              col  <= (colin_q >= COL_W'(SCREEN_COLS)) ? COL_W'(SCREEN_COLS - 1) : colin_q;
            end
            CMD_CLEAR: begin
              ring       <= '0;
              line       <= '0;
              col        <= '0;
              view       <= '0;
              sweep_attr <= attr;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd_q   <= in_cmd;
      ch_q    <= in_char;
      row_q   <= in_row;
      colin_q <= in_col;
    end
    if (state == S_EXEC) begin
      if (cmd_q == CMD_READ_CELL && !rc_oob && !rc_hit) begin
        word <= {attr, CH_SPACE};
      end else begin
        word <= '0;
      end
    end else if (state == S_READ) begin
      word <= rd_data;
    end
  end

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col < COL_W'(SCREEN_COLS))
    else $error("cursor column left the screen width");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_RESULT) |-> !req.we && !req.re)
    else $error("store accessed while no command is in progress");

  a_read_then_capture: assert property (@(posedge clk) disable iff (rst)
    req.re |=> state == S_READ)
    else $error("store read not followed by data capture");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while one is in progress");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    res_load |-> res.cursor_pos <= POS_W'(SCREEN_ROWS * SCREEN_COLS))
    else $error("cursor report out of range");

endmodule

// ===== hdl/text_console_with_scrollback.sv =====
// ----------------------------------------------------------------------------
// text_console_with_scrollback
// Text terminal engine over an 80-column ring of 256 scrollback rows.
// ----------------------------------------------------------------------------
// Channel   Handshake                    Payload
// s_axis    s_axis_tvalid/s_axis_tready  cmd, char_code, screen_row, screen_col
// m_axis    m_axis_tvalid/m_axis_tready  cell_word, cursor_pos
// cfg       cfg_valid/cfg_ready          attribute
//
// An item is accepted in S_IDLE, executed in S_EXEC and its result is
// loaded into the output register in S_RESULT; a read_cell of a stored cell
// also passes through S_READ, which captures the registered memory read.
// A put_char that overflows the history blanks one row in S_BLANK first.
// Reset and clear sweep all 20480 cells at one write per cycle; no item is
// accepted during the sweep, while configuration writes are always taken.
// A full output register holds the sequencer until the result is taken.
// ----------------------------------------------------------------------------
module text_console_with_scrollback
  import txc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] cmd, [10:3] char_code, [15:11] screen_row, [22:16] screen_col
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] cell_word, [26:16] cursor_pos
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  store_req_t        req;
  logic [CELL_W-1:0] rd_data;
  logic              out_free;
  logic              res_load;
  result_t           res;

  assign cfg_ready = 1'b1;

  txc_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  txc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (s_axis_tdata[2:0]),
    .in_char   (s_axis_tdata[10:3]),
    .in_row    (s_axis_tdata[15:11]),
    .in_col    (s_axis_tdata[22:16]),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .req       (req),
    .rd_data   (rd_data),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res)
  );

  txc_oreg u_oreg (
    .clk           (clk),
    .rst           (rst),
    .load          (res_load),
    .res           (res),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
